### src/assert_macros.svh
// Assertion macros used by the checker file.
// The macros expect clk, and all but CDDB_ASSERT_NEXT_ALWAYS also rst_n, to be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDDB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cddb assertion failed");

// Next-cycle implication, disabled during reset.
`define CDDB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cddb assertion failed");

// Next-cycle implication that also holds across reset.
`define CDDB_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cddb assertion failed");

`endif

### src/cddb_pkg.sv
// Package for the CD disc id calculator: transaction types, constants, helpers.
// No dependencies.
`timescale 1ns / 1ps

package cddb_pkg;

  localparam int CDDB_MAX_TRACKS = 99;

  localparam int MIN_W    = 7;
  localparam int SEC_W    = 6;
  localparam int FRM_W    = 7;
  localparam int TSEC_W   = 13;
  localparam int FOFF_W   = 19;
  localparam int ID_W     = 32;
  localparam int TRACK_W  = 7;
  localparam int DSUM_W   = 6;
  localparam int DIGIT2_W = 7;

  localparam int CDDB_SEC_PER_MIN    = 60;
  localparam int CDDB_FRAMES_PER_MIN = 4500;
  localparam int CDDB_FRAMES_PER_SEC = 75;
  localparam int CDDB_ID_SUM_MOD     = 255;
  localparam int CDDB_HUNDRED        = 100;
  localparam int CDDB_TEN            = 10;

  // floor(x / 100) = (x * 5243) >> 19 for x < 43699
  localparam int CDDB_DIV100_MUL   = 5243;
  localparam int CDDB_DIV100_SHIFT = 19;
  // floor(x / 10) = (x * 205) >> 11 for x < 1029
  localparam int CDDB_DIV10_MUL    = 205;
  localparam int CDDB_DIV10_SHIFT  = 11;

  typedef struct packed {
    logic [MIN_W-1:0] entry_minutes;
    logic [SEC_W-1:0] entry_seconds;
    logic [FRM_W-1:0] entry_frames;
    logic             is_leadout;
  } cddb_in_t;

  typedef struct packed {
    logic [FOFF_W-1:0]  frame_offset;
    logic [ID_W-1:0]    disc_id;
    logic [TSEC_W-1:0]  disc_length_seconds;
    logic [TRACK_W-1:0] track_count;
    logic               id_valid;
    logic               too_many_tracks;
  } cddb_out_t;

  // Preprocessed entry handed from the front pipeline to the state stage.
  typedef struct packed {
    logic               is_leadout;
    logic [TSEC_W-1:0]  total_secs;
    logic [FOFF_W-1:0]  frame_offset;
    logic [DSUM_W-1:0]  digit_sum;
  } cddb_entry_t;

  // Digit sum of a value below 100.
  function automatic logic [DSUM_W-1:0] cddb_digit_sum2(input logic [DIGIT2_W-1:0] v);
    logic [17:0]         prod;
    logic [3:0]          tens;
    logic [DIGIT2_W-1:0] ones;
    prod = 18'(v) * 18'(CDDB_DIV10_MUL);
    tens = 4'(prod >> CDDB_DIV10_SHIFT);
    ones = v - DIGIT2_W'(DIGIT2_W'(tens) * DIGIT2_W'(CDDB_TEN));
    return DSUM_W'(tens) + DSUM_W'(ones[3:0]);
  endfunction

endpackage

### src/cddb_entry_pipe.sv
// Front pipeline: input register, time conversion, split into hundreds and
// remainder, digit sum. Depends on cddb_pkg.
`timescale 1ns / 1ps

module cddb_entry_pipe import cddb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic        in_valid,
  input  cddb_in_t    in_data,
  output logic        ent_valid,
  output cddb_entry_t ent
);

  // stage A: input register
  logic     a_valid_r;
  cddb_in_t a_data_r;

  // stage B: seconds and frame offset
  logic              b_valid_r;
  logic              b_leadout_r;
  logic [TSEC_W-1:0] b_tsec_r;
  logic [FOFF_W-1:0] b_foff_r;
  logic [TSEC_W-1:0] b_tsec_nxt;
  logic [FOFF_W-1:0] b_foff_nxt;

  // stage C: hundreds and remainder of seconds
  logic                c_valid_r;
  logic                c_leadout_r;
  logic [TSEC_W-1:0]   c_tsec_r;
  logic [FOFF_W-1:0]   c_foff_r;
  logic [DIGIT2_W-1:0] c_q100_r;
  logic [DIGIT2_W-1:0] c_r100_r;
  logic [DIGIT2_W-1:0] c_q100_nxt;
  logic [DIGIT2_W-1:0] c_r100_nxt;
  logic [25:0]         div_prod;

  always_comb begin
    b_tsec_nxt = TSEC_W'(TSEC_W'(a_data_r.entry_minutes) * TSEC_W'(CDDB_SEC_PER_MIN))
               + TSEC_W'(a_data_r.entry_seconds);
    b_foff_nxt = FOFF_W'(FOFF_W'(a_data_r.entry_minutes) * FOFF_W'(CDDB_FRAMES_PER_MIN))
               + FOFF_W'(FOFF_W'(a_data_r.entry_seconds) * FOFF_W'(CDDB_FRAMES_PER_SEC))
               + FOFF_W'(a_data_r.entry_frames);
  end

  always_comb begin
    div_prod   = 26'(b_tsec_r) * 26'(CDDB_DIV100_MUL);
    c_q100_nxt = DIGIT2_W'(div_prod >> CDDB_DIV100_SHIFT);
    c_r100_nxt = DIGIT2_W'(b_tsec_r - TSEC_W'(TSEC_W'(c_q100_nxt) * TSEC_W'(CDDB_HUNDRED)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_data_r    <= in_data;
      b_leadout_r <= a_data_r.is_leadout;
      b_tsec_r    <= b_tsec_nxt;
      b_foff_r    <= b_foff_nxt;
      c_leadout_r <= b_leadout_r;
      c_tsec_r    <= b_tsec_r;
      c_foff_r    <= b_foff_r;
      c_q100_r    <= c_q100_nxt;
      c_r100_r    <= c_r100_nxt;
    end
  end

  assign ent_valid        = c_valid_r;
  assign ent.is_leadout   = c_leadout_r;
  assign ent.total_secs   = c_tsec_r;
  assign ent.frame_offset = c_foff_r;
  assign ent.digit_sum    = cddb_digit_sum2(c_q100_r) + cddb_digit_sum2(c_r100_r);

endmodule

### src/cd_disc_id_calculator.sv
// CD disc id calculator, top level: per-disc state and result register.
// Depends on cddb_pkg and cddb_entry_pipe.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one table-of-contents
//   entry per transaction: track starts in order, then a lead-out entry.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   result per entry: the frame offset for a track, or the disc id, length
//   and track count for a lead-out (id_valid set). Per-disc state clears
//   after each lead-out.
//   Pipeline: an accepted entry passes the input register, two conversion
//   stages and the result register before its result is presented.
//   Throughput: one entry per cycle while out_stall holds no waiting result;
//   the per-disc state is updated once per entry in the last stage.
//   Stall: while out_stall holds a waiting result, the whole pipeline freezes
//   and in_stall is raised; with the result register empty, in_stall is low.
//   Reset (rst_n low, synchronous) empties the pipeline and clears the
//   per-disc state.
//   Tracks beyond MAX_TRACKS are not counted and set too_many_tracks.

module cd_disc_id_calculator import cddb_pkg::*; #(
  parameter int MAX_TRACKS = CDDB_MAX_TRACKS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cddb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cddb_out_t out_data
);

  logic        advance;
  logic        ent_valid;
  cddb_entry_t ent;

  logic [7:0]         dsum_mod_r;
  logic [TSEC_W-1:0]  first_secs_r;
  logic [TRACK_W-1:0] tracks_r;
  logic               ovf_r;
  logic               out_valid_r;
  cddb_out_t          out_data_r;

  logic [7:0]         dsum_mod_nxt;
  logic [TSEC_W-1:0]  first_secs_nxt;
  logic [TRACK_W-1:0] tracks_nxt;
  logic               ovf_nxt;
  cddb_out_t          res_nxt;

  logic [8:0]  sum9;
  logic [8:0]  sum_wrapped;
  logic [23:0] diff24;
  logic [23:0] id_hi;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  cddb_entry_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  always_comb begin
    sum9        = 9'(dsum_mod_r) + 9'(ent.digit_sum);
    sum_wrapped = (sum9 >= 9'(CDDB_ID_SUM_MOD)) ? sum9 - 9'(CDDB_ID_SUM_MOD) : sum9;
    diff24      = (tracks_r != '0) ? 24'(ent.total_secs) - 24'(first_secs_r) : '0;
    id_hi       = diff24 + {dsum_mod_r, 16'b0};
  end

  always_comb begin
    dsum_mod_nxt   = dsum_mod_r;
    first_secs_nxt = first_secs_r;
    tracks_nxt     = tracks_r;
    ovf_nxt        = ovf_r;
    res_nxt        = '0;
    if (!ent.is_leadout) begin
      if (tracks_r >= TRACK_W'(MAX_TRACKS)) begin
        ovf_nxt                 = 1'b1;
        res_nxt.track_count     = tracks_r;
        res_nxt.too_many_tracks = 1'b1;
      end else begin
        if (tracks_r == '0) begin
          first_secs_nxt = ent.total_secs;
        end
        dsum_mod_nxt            = 8'(sum_wrapped);
        tracks_nxt              = TRACK_W'(tracks_r + 1'b1);
        res_nxt.frame_offset    = ent.frame_offset;
        res_nxt.track_count     = TRACK_W'(tracks_r + 1'b1);
        res_nxt.too_many_tracks = ovf_r;
      end
    end else begin
      res_nxt.disc_id             = {id_hi, 8'(tracks_r)};
      res_nxt.disc_length_seconds = ent.total_secs;
      res_nxt.track_count         = tracks_r;
      res_nxt.id_valid            = 1'b1;
      res_nxt.too_many_tracks     = ovf_r;
      dsum_mod_nxt                = '0;
      first_secs_nxt              = '0;
      tracks_nxt                  = '0;
      ovf_nxt                     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsum_mod_r   <= '0;
      first_secs_r <= '0;
      tracks_r     <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ent_valid;
      if (ent_valid) begin
        dsum_mod_r   <= dsum_mod_nxt;
        first_secs_r <= first_secs_nxt;
        tracks_r     <= tracks_nxt;
        ovf_r        <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ent_valid) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/cddb_checker.sv
// Port-level checker for cd_disc_id_calculator, attached by bind.
// Depends on cddb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cddb_checker import cddb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input cddb_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input cddb_out_t out_data
);

  logic lead_fields_zero;

  assign lead_fields_zero = (out_data.disc_id == '0) && (out_data.disc_length_seconds == '0);

  `CDDB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
  `CDDB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `CDDB_ASSERT_IMPL(a_no_stall_when_empty, !out_valid, !in_stall)
  `CDDB_ASSERT_IMPL(a_track_fields, out_valid && !out_data.id_valid, lead_fields_zero)
  `CDDB_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind cd_disc_id_calculator cddb_checker u_cddb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
